>>> rtl/uopc_pkg.sv
package uopc_pkg;

	localparam int CORDIC_ITERS = 16;
	localparam int QUO_BITS     = 32;

	localparam logic signed [16:0] PI_Q13      = 17'sd25736;
	localparam logic signed [16:0] HALF_PI_Q13 = 17'sd12868;
	localparam logic signed [31:0] CORDIC_X0   = 32'sd652032874;
	localparam logic [15:0]        OFFSET_RESET = 16'd19661;

	typedef enum logic {
		REG_PROP_GAIN   = 1'b0,
		REG_OFFSET_DIST = 1'b1
	} cfg_reg_t;

	// atan(2^-i) in radians Q.16
	function automatic logic [15:0] atan_q16(input logic [3:0] i);
		logic [15:0] r;
		case (i)
			4'd0:    r = 16'd51472;
			4'd1:    r = 16'd30385;
			4'd2:    r = 16'd16055;
			4'd3:    r = 16'd8150;
			4'd4:    r = 16'd4091;
			4'd5:    r = 16'd2047;
			4'd6:    r = 16'd1024;
			4'd7:    r = 16'd512;
			4'd8:    r = 16'd256;
			4'd9:    r = 16'd128;
			4'd10:   r = 16'd64;
			4'd11:   r = 16'd32;
			4'd12:   r = 16'd16;
			4'd13:   r = 16'd8;
			4'd14:   r = 16'd4;
			4'd15:   r = 16'd2;
			default: r = 16'd0;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/unicycle_offset_point_controller_top.sv
// Channel   | Ports                                              | Handshake
// ----------+----------------------------------------------------+--------------------------
// item in   | pose_x, pose_y, heading, target_x, target_y        | start && !busy
// result    | linear_velocity, angular_velocity                  | done, one cycle, no stall
// config    | cfg_index, cfg_wdata                               | cfg_we
//
// Fully pipelined: one item per cycle. Each result is registered in the output stage
// and is shown on the outputs while done is high.
// The pipeline holds the 16 CORDIC rotation stages and the 32 one-bit quotient stages
// of the angular-rate divider; the rest are multiply, add and rounding stages.
// busy is never raised. arst_n resets valid bits and config registers only.
// Results cannot be held off: done pulses for one cycle per item.
module unicycle_offset_point_controller_top
	import uopc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] pose_x,
	input  logic signed [31:0] pose_y,
	input  logic signed [15:0] heading,
	input  logic signed [31:0] target_x,
	input  logic signed [31:0] target_y,
	output logic               done,
	output logic signed [31:0] linear_velocity,
	output logic signed [31:0] angular_velocity,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_wdata
);

	localparam int LastStage = 30 + QUO_BITS; // 62: output register stage
	localparam int DivFirst  = 29;

	// ---------------- configuration ----------------
	logic [15:0] prop_gain_q;
	logic [15:0] offset_distance_q;
	logic [15:0] d_eff;
	logic [19:0] den;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q       <= '0;
			offset_distance_q <= OFFSET_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_PROP_GAIN:   prop_gain_q       <= cfg_wdata;
				REG_OFFSET_DIST: offset_distance_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// zero distance behaves as one LSB
	assign d_eff = (offset_distance_q == '0) ? 16'd1 : offset_distance_q;
	assign den   = {d_eff, 4'b0000};

	// ---------------- valid line ----------------
	logic [LastStage:1] vld_s;
	logic               accept;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[LastStage-1:1], accept};
		end
	end

	// ---------------- s1: heading fold, CORDIC seed ----------------
	logic signed [31:0] cx_s  [0:CORDIC_ITERS];
	logic signed [31:0] cy_s  [0:CORDIC_ITERS];
	logic signed [19:0] cz_s  [0:CORDIC_ITERS];
	logic signed [31:0] px0_s [0:CORDIC_ITERS];
	logic signed [31:0] py0_s [0:CORDIC_ITERS];
	logic signed [31:0] tx_s  [0:CORDIC_ITERS];
	logic signed [31:0] ty_s  [0:CORDIC_ITERS];
	logic               neg_s [0:CORDIC_ITERS];

	logic signed [16:0] hd_ext;
	logic signed [16:0] a_fold;
	logic               a_neg;

	always_comb begin
		hd_ext = {heading[15], heading};
		a_fold = hd_ext;
		a_neg  = 1'b0;
		if (hd_ext > HALF_PI_Q13) begin
			a_fold = hd_ext - PI_Q13;
			a_neg  = 1'b1;
		end else if (hd_ext < -HALF_PI_Q13) begin
			a_fold = hd_ext + PI_Q13;
			a_neg  = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		cx_s[0]  <= CORDIC_X0;
		cy_s[0]  <= '0;
		cz_s[0]  <= {a_fold, 3'b000};
		neg_s[0] <= a_neg;
		px0_s[0] <= pose_x;
		py0_s[0] <= pose_y;
		tx_s[0]  <= target_x;
		ty_s[0]  <= target_y;
	end

	// ---------------- s2..s17: CORDIC rotation stages ----------------
	for (genvar k = 0; k < CORDIC_ITERS; k++) begin : g_cordic
		logic signed [31:0] dx;
		logic signed [31:0] dy;
		logic signed [19:0] dz;

		assign dx = cy_s[k] >>> k;
		assign dy = cx_s[k] >>> k;
		assign dz = $signed({4'b0000, atan_q16(4'(k))});

		always_ff @(posedge clk) begin
			if (!cz_s[k][19]) begin
				cx_s[k+1] <= cx_s[k] - dx;
				cy_s[k+1] <= cy_s[k] + dy;
				cz_s[k+1] <= cz_s[k] - dz;
			end else begin
				cx_s[k+1] <= cx_s[k] + dx;
				cy_s[k+1] <= cy_s[k] - dy;
				cz_s[k+1] <= cz_s[k] + dz;
			end
			neg_s[k+1] <= neg_s[k];
			px0_s[k+1] <= px0_s[k];
			py0_s[k+1] <= py0_s[k];
			tx_s[k+1]  <= tx_s[k];
			ty_s[k+1]  <= ty_s[k];
		end
	end

	// ---------------- s18: round to Q.20, fold sign ----------------
	logic signed [32:0] cr_sum;
	logic signed [32:0] sr_sum;
	logic signed [21:0] c_rnd;
	logic signed [21:0] s_rnd;
	logic signed [21:0] c_s18, s_s18;
	logic signed [31:0] x_s18, y_s18, tx_s18, ty_s18;

	assign cr_sum = {cx_s[CORDIC_ITERS][31], cx_s[CORDIC_ITERS]} + 33'sd512;
	assign sr_sum = {cy_s[CORDIC_ITERS][31], cy_s[CORDIC_ITERS]} + 33'sd512;
	assign c_rnd  = cr_sum[31:10];
	assign s_rnd  = sr_sum[31:10];

	always_ff @(posedge clk) begin
		c_s18  <= neg_s[CORDIC_ITERS] ? -c_rnd : c_rnd;
		s_s18  <= neg_s[CORDIC_ITERS] ? -s_rnd : s_rnd;
		x_s18  <= px0_s[CORDIC_ITERS];
		y_s18  <= py0_s[CORDIC_ITERS];
		tx_s18 <= tx_s[CORDIC_ITERS];
		ty_s18 <= ty_s[CORDIC_ITERS];
	end

	// ---------------- s19: d*cos, d*sin ----------------
	logic signed [38:0] dc_s19, ds_s19;
	logic signed [21:0] c_s19, s_s19;
	logic signed [31:0] x_s19, y_s19, tx_s19, ty_s19;

	always_ff @(posedge clk) begin
		dc_s19 <= $signed({1'b0, d_eff}) * c_s18;
		ds_s19 <= $signed({1'b0, d_eff}) * s_s18;
		c_s19  <= c_s18;
		s_s19  <= s_s18;
		x_s19  <= x_s18;
		y_s19  <= y_s18;
		tx_s19 <= tx_s18;
		ty_s19 <= ty_s18;
	end

	// ---------------- s20: control point ----------------
	logic signed [38:0] dcr, dsr;
	logic signed [33:0] px_s20, py_s20;
	logic signed [21:0] c_s20, s_s20;
	logic signed [31:0] tx_s20, ty_s20;

	assign dcr = dc_s19 + 39'sd524288;
	assign dsr = ds_s19 + 39'sd524288;

	always_ff @(posedge clk) begin
		px_s20 <= {{2{x_s19[31]}}, x_s19} + {{15{dcr[38]}}, dcr[38:20]};
		py_s20 <= {{2{y_s19[31]}}, y_s19} + {{15{dsr[38]}}, dsr[38:20]};
		c_s20  <= c_s19;
		s_s20  <= s_s19;
		tx_s20 <= tx_s19;
		ty_s20 <= ty_s19;
	end

	// ---------------- s21: position error ----------------
	logic signed [34:0] ex_s21, ey_s21;
	logic signed [21:0] c_s21, s_s21;

	always_ff @(posedge clk) begin
		ex_s21 <= {{3{tx_s20[31]}}, tx_s20} - {px_s20[33], px_s20};
		ey_s21 <= {{3{ty_s20[31]}}, ty_s20} - {py_s20[33], py_s20};
		c_s21  <= c_s20;
		s_s21  <= s_s20;
	end

	// ---------------- s22: gain multiply ----------------
	logic signed [51:0] kx_s22, ky_s22;
	logic signed [21:0] c_s22, s_s22;

	always_ff @(posedge clk) begin
		kx_s22 <= ex_s21 * $signed({1'b0, prop_gain_q});
		ky_s22 <= ey_s21 * $signed({1'b0, prop_gain_q});
		c_s22  <= c_s21;
		s_s22  <= s_s21;
	end

	// ---------------- s23: round to Q16.16 ----------------
	logic signed [51:0] kxr, kyr;
	logic signed [43:0] ux_s23, uy_s23;
	logic signed [21:0] c_s23, s_s23;

	assign kxr = kx_s22 + 52'sd128;
	assign kyr = ky_s22 + 52'sd128;

	always_ff @(posedge clk) begin
		ux_s23 <= kxr[51:8];
		uy_s23 <= kyr[51:8];
		c_s23  <= c_s22;
		s_s23  <= s_s22;
	end

	// ---------------- s24: split partial products ----------------
	logic signed [43:0] cuxh_s24, suyh_s24, cuyh_s24, suxh_s24;
	logic signed [44:0] cuxl_s24, suyl_s24, cuyl_s24, suxl_s24;

	always_ff @(posedge clk) begin
		cuxh_s24 <= c_s23 * $signed(ux_s23[43:22]);
		suyh_s24 <= s_s23 * $signed(uy_s23[43:22]);
		cuyh_s24 <= c_s23 * $signed(uy_s23[43:22]);
		suxh_s24 <= s_s23 * $signed(ux_s23[43:22]);
		cuxl_s24 <= c_s23 * $signed({1'b0, ux_s23[21:0]});
		suyl_s24 <= s_s23 * $signed({1'b0, uy_s23[21:0]});
		cuyl_s24 <= c_s23 * $signed({1'b0, uy_s23[21:0]});
		suxl_s24 <= s_s23 * $signed({1'b0, ux_s23[21:0]});
	end

	// ---------------- s25: join partial products ----------------
	logic signed [66:0] cux_s25, suy_s25, cuy_s25, sux_s25;

	always_ff @(posedge clk) begin
		cux_s25 <= {cuxh_s24[43], cuxh_s24, 22'd0} + {{22{cuxl_s24[44]}}, cuxl_s24};
		suy_s25 <= {suyh_s24[43], suyh_s24, 22'd0} + {{22{suyl_s24[44]}}, suyl_s24};
		cuy_s25 <= {cuyh_s24[43], cuyh_s24, 22'd0} + {{22{cuyl_s24[44]}}, cuyl_s24};
		sux_s25 <= {suxh_s24[43], suxh_s24, 22'd0} + {{22{suxl_s24[44]}}, suxl_s24};
	end

	// ---------------- s26: Jacobian inverse sums ----------------
	logic signed [66:0] vsum_s26, num_s26;

	always_ff @(posedge clk) begin
		vsum_s26 <= cux_s25 + suy_s25;
		num_s26  <= cuy_s25 - sux_s25;
	end

	// ---------------- s27: round v, magnitude of w numerator ----------------
	logic signed [66:0] vsr;
	logic signed [46:0] vr_s27;
	logic [66:0]        mag_s27;
	logic               wneg_s27;

	assign vsr = vsum_s26 + 67'sd524288;

	always_ff @(posedge clk) begin
		vr_s27   <= vsr[66:20];
		mag_s27  <= num_s26[66] ? 67'(-num_s26) : 67'(num_s26);
		wneg_s27 <= num_s26[66];
	end

	// ---------------- s28: saturate v, add half divisor ----------------
	logic signed [31:0] v_s28;
	logic [67:0]        n_s28;
	logic               wneg_s28;

	always_ff @(posedge clk) begin
		if (vr_s27 > 47'sd2147483647) begin
			v_s28 <= 32'sh7FFF_FFFF;
		end else if (vr_s27 < -47'sd2147483648) begin
			v_s28 <= 32'sh8000_0000;
		end else begin
			v_s28 <= vr_s27[31:0];
		end
		n_s28    <= {1'b0, mag_s27} + {49'd0, d_eff, 3'b000};
		wneg_s28 <= wneg_s27;
	end

	// ---------------- s29..s61: restoring divider, one bit a stage ----------------
	logic [19:0]        dr_s   [0:QUO_BITS];
	logic [31:0]        dn_s   [0:QUO_BITS];
	logic [31:0]        dq_s   [0:QUO_BITS];
	logic               dovf_s [0:QUO_BITS];
	logic               dneg_s [0:QUO_BITS];
	logic signed [31:0] dv_s   [0:QUO_BITS];

	always_ff @(posedge clk) begin
		// quotient would need more than 32 bits
		dovf_s[0] <= (n_s28[67:32] >= {16'd0, den});
		dr_s[0]   <= n_s28[51:32];
		dn_s[0]   <= n_s28[31:0];
		dq_s[0]   <= '0;
		dneg_s[0] <= wneg_s28;
		dv_s[0]   <= v_s28;
	end

	for (genvar k = 0; k < QUO_BITS; k++) begin : g_div
		logic [20:0] rp;
		logic [20:0] rd;
		logic        ge;

		assign rp = {dr_s[k], dn_s[k][31]};
		assign ge = (rp >= {1'b0, den});
		assign rd = rp - {1'b0, den};

		always_ff @(posedge clk) begin
			dr_s[k+1]   <= ge ? rd[19:0] : rp[19:0];
			dn_s[k+1]   <= {dn_s[k][30:0], 1'b0};
			dq_s[k+1]   <= {dq_s[k][30:0], ge};
			dovf_s[k+1] <= dovf_s[k];
			dneg_s[k+1] <= dneg_s[k];
			dv_s[k+1]   <= dv_s[k];
		end
	end

	// ---------------- s62: sign, saturate, output ----------------
	logic [31:0] q_fin;

	assign q_fin = dq_s[QUO_BITS];

	always_ff @(posedge clk) begin
		linear_velocity <= dv_s[QUO_BITS];
		if (!dneg_s[QUO_BITS]) begin
			if (dovf_s[QUO_BITS] || q_fin[31]) begin
				angular_velocity <= 32'sh7FFF_FFFF;
			end else begin
				angular_velocity <= $signed(q_fin);
			end
		end else begin
			if (dovf_s[QUO_BITS] || (q_fin > 32'h8000_0000)) begin
				angular_velocity <= 32'sh8000_0000;
			end else begin
				angular_velocity <= $signed(-q_fin);
			end
		end
	end

	assign done = vld_s[LastStage];

	// ---------------- assertions ----------------
	a_fold_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[1] |-> (cz_s[0] <= 20'sd102944) && (cz_s[0] >= -20'sd102944))
		else $error("folded heading out of quarter range");

	a_cs_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[18] |-> (c_s18 <= 22'sd1048592) && (c_s18 >= -22'sd1048592)
			&& (s_s18 <= 22'sd1048592) && (s_s18 >= -22'sd1048592))
		else $error("cos/sin exceed unit magnitude");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[DivFirst + QUO_BITS] && !dovf_s[QUO_BITS]) |-> (dr_s[QUO_BITS] < den))
		else $error("divider remainder not below divisor");

	a_div_lat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(vld_s[DivFirst], QUO_BITS + 1))
		else $error("result without item entering divider");

endmodule
